FILE: src/dwrr_pkg.sv
`default_nettype none
package dwrr_pkg;

    localparam int NUM_QUEUES = 3;
    localparam int DSCP_W     = 6;
    localparam int WEIGHT_W   = 8;
    localparam int QIDX_W     = 2;
    localparam int CFG_IDX_W  = 2;

    typedef logic [QIDX_W-1:0]   qidx_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [DSCP_W-1:0]   dscp_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED       = 3'd0,
        ST_DROP_FULL      = 3'd1,
        ST_DROP_NON_IPV4  = 3'd2,
        ST_DEQUEUED       = 3'd3,
        ST_EMPTY          = 3'd4
    } status_t;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LOW_LATENCY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BROADBAND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MACHINE_TYPE = 2'd2;

    localparam dscp_t DSCP_LOW_LATENCY = 6'd46;
    localparam dscp_t DSCP_BROADBAND   = 6'd40;
    localparam dscp_t DSCP_MACHINE     = 6'd8;

    localparam qidx_t Q_LOW_LATENCY  = 2'd0;
    localparam qidx_t Q_BROADBAND    = 2'd1;
    localparam qidx_t Q_MACHINE_TYPE = 2'd2;

    localparam weight_t WEIGHT_RESET_LOW_LATENCY  = 8'd10;
    localparam weight_t WEIGHT_RESET_BROADBAND    = 8'd6;
    localparam weight_t WEIGHT_RESET_MACHINE_TYPE = 8'd4;

endpackage
`default_nettype wire

FILE: src/dwrr_if.sv
`default_nettype none
interface dwrr_req_if #(parameter int HANDLE_BITS = 16);
    logic                       valid;
    logic                       ready;
    logic                       kind;
    dwrr_pkg::dscp_t            dscp;
    logic                       is_ipv4;
    logic [HANDLE_BITS-1:0]     packet_handle;

    modport source (output valid, kind, dscp, is_ipv4, packet_handle, input ready);
    modport sink   (input valid, kind, dscp, is_ipv4, packet_handle, output ready);
endinterface

interface dwrr_rsp_if #(parameter int HANDLE_BITS = 16);
    logic                       valid;
    logic                       ready;
    dwrr_pkg::status_t          status;
    dwrr_pkg::qidx_t            queue_index;
    logic [HANDLE_BITS-1:0]     out_handle;

    modport source (output valid, status, queue_index, out_handle, input ready);
    modport sink   (input valid, status, queue_index, out_handle, output ready);
endinterface

interface dwrr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [dwrr_pkg::CFG_IDX_W-1:0]       index;
    dwrr_pkg::weight_t                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/dscp_weighted_round_robin_queue.sv
// Three drop-tail packet-handle FIFOs behind a weighted round-robin scheduler.
// req channel: kind selects enqueue (dscp, is_ipv4, packet_handle) or a
// dequeue request. rsp channel: exactly one response per request with status,
// queue_index and out_handle. cfg channel: weight writes, index 0..2, always
// ready; write only while no request is in flight.
// An enqueue or an empty dequeue writes its response straight into the output
// register when it executes; a served dequeue first reads the shared handle
// memory (3 x QUEUE_DEPTH entries) into a read register, then loads the response.
// One request at a time: req is ready only while idle, so no new request is
// taken while a dequeue reads memory or a parked request waits.
// One output register holds the response. If rsp stalls, a request is still
// accepted and parked; it executes once the response slot frees.
// Reset clears pointers, occupancies and the scheduler position, restores
// the weights to 10, 6, 4 and loads the credits from them. The handle memory
// is not cleared; only written entries are ever read.
`default_nettype none
module dscp_weighted_round_robin_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dwrr_req_if.sink    req,
    dwrr_rsp_if.source  rsp,
    dwrr_cfg_if.sink    cfg
);

    localparam int NQ        = dwrr_pkg::NUM_QUEUES;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NQ * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int WW        = dwrr_pkg::WEIGHT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t                     state_reg;
    logic [PTR_W-1:0]           head_reg   [NQ];
    logic [PTR_W-1:0]           tail_reg   [NQ];
    logic [OCC_W-1:0]           occ_reg    [NQ];
    dwrr_pkg::weight_t          credit_reg [NQ];
    dwrr_pkg::weight_t          weight_reg [NQ];
    dwrr_pkg::qidx_t            last_reg;

    logic                       req_kind_reg;
    dwrr_pkg::dscp_t            req_dscp_reg;
    logic                       req_ipv4_reg;
    logic [HANDLE_BITS-1:0]     req_handle_reg;

    logic                       rsp_valid_reg;
    dwrr_pkg::status_t          rsp_status_reg;
    dwrr_pkg::qidx_t            rsp_qidx_reg;
    logic [HANDLE_BITS-1:0]     rsp_handle_reg;

    logic [HANDLE_BITS-1:0]     mem [MEM_DEPTH];
    logic [HANDLE_BITS-1:0]     mem_rdata_reg;

    logic                       cur_kind;
    dwrr_pkg::dscp_t            cur_dscp;
    logic                       cur_ipv4;
    logic [HANDLE_BITS-1:0]     cur_handle;

    logic                       out_free;
    logic                       go;
    logic                       exec_enq;
    logic                       exec_deq;
    dwrr_pkg::qidx_t            enq_q;
    logic                       enq_full;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    dwrr_pkg::weight_t          reload_val [NQ];
    dwrr_pkg::weight_t          credit_next [NQ];
    logic                       deq_found;
    dwrr_pkg::qidx_t            deq_q;

    function automatic dwrr_pkg::qidx_t ring_idx(
        input dwrr_pkg::qidx_t base,
        input dwrr_pkg::qidx_t step
    );
        logic [2:0] sum;
        sum = {1'b0, base} + {1'b0, step};
        return (sum >= 3'(NQ)) ? 2'(sum - 3'(NQ)) : sum[1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.queue_index = rsp_qidx_reg;
    assign rsp.out_handle  = rsp_handle_reg;

    assign cur_kind   = (state_reg == S_IDLE) ? req.kind          : req_kind_reg;
    assign cur_dscp   = (state_reg == S_IDLE) ? req.dscp          : req_dscp_reg;
    assign cur_ipv4   = (state_reg == S_IDLE) ? req.is_ipv4       : req_ipv4_reg;
    assign cur_handle = (state_reg == S_IDLE) ? req.packet_handle : req_handle_reg;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign go       = out_free && ((state_reg == S_IDLE && req.valid) || state_reg == S_EXEC);
    assign exec_enq = go && (cur_kind == dwrr_pkg::KIND_ENQUEUE);
    assign exec_deq = go && (cur_kind == dwrr_pkg::KIND_DEQUEUE);

    always_comb
    begin
        case (cur_dscp)
            dwrr_pkg::DSCP_LOW_LATENCY: enq_q = dwrr_pkg::Q_LOW_LATENCY;
            dwrr_pkg::DSCP_BROADBAND:   enq_q = dwrr_pkg::Q_BROADBAND;
            dwrr_pkg::DSCP_MACHINE:     enq_q = dwrr_pkg::Q_MACHINE_TYPE;
            default:                    enq_q = dwrr_pkg::Q_BROADBAND;
        endcase
    end

    assign enq_full = (occ_reg[enq_q] == OCC_W'(QUEUE_DEPTH));
    assign mem_we   = exec_enq && cur_ipv4 && !enq_full;
    assign mem_re   = exec_deq && deq_found;
    assign wr_addr  = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[enq_q]);
    assign rd_addr  = ADDR_W'(deq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[deq_q]);

    always_comb
    begin
        for (int q = 0; q < NQ; q++)
        begin
            reload_val[q] = (weight_reg[q] == '0) ? WW'(1) : weight_reg[q];
        end
    end

    // ring search from the last served queue; empty queues reload as passed, and all reload if no busy queue has credit
    always_comb
    begin
        dwrr_pkg::weight_t  credit_srch [NQ];
        logic               found1;
        logic               found2;
        logic               any_busy;
        dwrr_pkg::qidx_t    q1;
        dwrr_pkg::qidx_t    q2;
        dwrr_pkg::qidx_t    qi;

        credit_srch = credit_reg;
        found1      = 1'b0;
        found2      = 1'b0;
        any_busy    = 1'b0;
        q1          = '0;
        q2          = '0;
        for (int i = 0; i < NQ; i++)
        begin
            qi = ring_idx(last_reg, 2'(i));
            if (!found1)
            begin
                if (credit_srch[qi] != '0 && occ_reg[qi] != '0)
                begin
                    found1 = 1'b1;
                    q1     = qi;
                end
                else if (occ_reg[qi] == '0)
                begin
                    credit_srch[qi] = reload_val[qi];
                end
            end
            if (!found2 && occ_reg[qi] != '0)
            begin
                found2 = 1'b1;
                q2     = qi;
            end
            any_busy = any_busy || (occ_reg[qi] != '0);
        end

        credit_next = credit_srch;
        if (found1)
        begin
            deq_found        = 1'b1;
            deq_q            = q1;
            credit_next[q1]  = credit_srch[q1] - WW'(1);
        end
        else if (any_busy)
        begin
            deq_found   = 1'b1;
            deq_q       = q2;
            credit_next = reload_val;
            credit_next[q2] = reload_val[q2] - WW'(1);
        end
        else
        begin
            deq_found = 1'b0;
            deq_q     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= dwrr_pkg::ST_ENQUEUED;
            rsp_qidx_reg   <= '0;
            rsp_handle_reg <= '0;
            for (int q = 0; q < NQ; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                occ_reg[q]  <= '0;
            end
            weight_reg[0] <= dwrr_pkg::WEIGHT_RESET_LOW_LATENCY;
            weight_reg[1] <= dwrr_pkg::WEIGHT_RESET_BROADBAND;
            weight_reg[2] <= dwrr_pkg::WEIGHT_RESET_MACHINE_TYPE;
            credit_reg[0] <= dwrr_pkg::WEIGHT_RESET_LOW_LATENCY;
            credit_reg[1] <= dwrr_pkg::WEIGHT_RESET_BROADBAND;
            credit_reg[2] <= dwrr_pkg::WEIGHT_RESET_MACHINE_TYPE;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    dwrr_pkg::REG_WEIGHT_LOW_LATENCY:  weight_reg[0] <= cfg.data;
                    dwrr_pkg::REG_WEIGHT_BROADBAND:    weight_reg[1] <= cfg.data;
                    dwrr_pkg::REG_WEIGHT_MACHINE_TYPE: weight_reg[2] <= cfg.data;
                    default: ;
                endcase
            end

            if (rsp_valid_reg && rsp.ready && !(exec_enq || (exec_deq && !deq_found)))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && !go)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: ;
                S_READ:
                begin
                    rsp_valid_reg  <= 1'b1;
                    rsp_status_reg <= dwrr_pkg::ST_DEQUEUED;
                    rsp_handle_reg <= mem_rdata_reg;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            if (exec_enq)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_handle_reg <= '0;
                state_reg      <= S_IDLE;
                if (!cur_ipv4)
                begin
                    rsp_status_reg <= dwrr_pkg::ST_DROP_NON_IPV4;
                    rsp_qidx_reg   <= '0;
                end
                else if (enq_full)
                begin
                    rsp_status_reg <= dwrr_pkg::ST_DROP_FULL;
                    rsp_qidx_reg   <= enq_q;
                end
                else
                begin
                    rsp_status_reg <= dwrr_pkg::ST_ENQUEUED;
                    rsp_qidx_reg   <= enq_q;
                    tail_reg[enq_q] <= ptr_inc(tail_reg[enq_q]);
                    occ_reg[enq_q]  <= occ_reg[enq_q] + OCC_W'(1);
                end
            end

            if (exec_deq)
            begin
                credit_reg <= credit_next;
                if (deq_found)
                begin
                    head_reg[deq_q] <= ptr_inc(head_reg[deq_q]);
                    occ_reg[deq_q]  <= occ_reg[deq_q] - OCC_W'(1);
                    last_reg        <= deq_q;
                    rsp_qidx_reg    <= deq_q;
                    state_reg       <= S_READ;
                end
                else
                begin
                    rsp_valid_reg  <= 1'b1;
                    rsp_status_reg <= dwrr_pkg::ST_EMPTY;
                    rsp_qidx_reg   <= '0;
                    rsp_handle_reg <= '0;
                    state_reg      <= S_IDLE;
                end
            end
        end
    end

    // capture every accepted request; the copy is used if it parks while the response slot is full
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_kind_reg   <= req.kind;
            req_dscp_reg   <= req.dscp;
            req_ipv4_reg   <= req.is_ipv4;
            req_handle_reg <= req.packet_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cur_handle;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/dwrr_checker.sv
`default_nettype none
module dwrr_checker #(
    parameter int HANDLE_BITS = 16
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    rsp_valid,
    input wire logic                    rsp_ready,
    input wire logic [2:0]              rsp_status,
    input wire logic [1:0]              rsp_queue_index,
    input wire logic [HANDLE_BITS-1:0]  rsp_out_handle
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_queue_index) && $stable(rsp_out_handle))
        else $error("stalled response changed");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    a_handle_only_on_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != dwrr_pkg::ST_DEQUEUED) |-> rsp_out_handle == '0)
        else $error("handle reported without a dequeue");

    a_queue_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == dwrr_pkg::ST_DROP_NON_IPV4
            || rsp_status == dwrr_pkg::ST_EMPTY) |-> rsp_queue_index == '0)
        else $error("queue index set on a response without a queue");

    a_queue_index_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_queue_index != 2'd3)
        else $error("queue index out of range");

endmodule

bind dscp_weighted_round_robin_queue dwrr_checker #(
    .HANDLE_BITS(HANDLE_BITS)
) u_dwrr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_queue_index (rsp.queue_index),
    .rsp_out_handle  (rsp.out_handle)
);
`default_nettype wire

FILE: tb/sv/dscp_weighted_round_robin_queue_tb.sv
`default_nettype none
module dscp_weighted_round_robin_queue_tb;
    import dwrr_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                   kind;
        dscp_t                  dscp;
        logic                   is_ipv4;
        logic [HANDLE_BITS-1:0] handle;
    } pkt_req_t;

    typedef struct packed {
        status_t                status;
        qidx_t                  queue_index;
        logic [HANDLE_BITS-1:0] handle;
    } pkt_rsp_t;

    typedef struct packed {
        logic     typed;
        pkt_req_t r;
        pkt_rsp_t e;
    } row_t;

    localparam pkt_rsp_t UNTYPED = '{ST_ENQUEUED, Q_LOW_LATENCY, 16'h0000};

    localparam logic [CFG_IDX_W-1:0] WEIGHT_REG [NUM_QUEUES] =
        '{REG_WEIGHT_LOW_LATENCY, REG_WEIGHT_BROADBAND, REG_WEIGHT_MACHINE_TYPE};

    localparam row_t DIRECTED [18] = '{
        '{1'b1, '{KIND_DEQUEUE, 6'd63, 1'b1, 16'hFFFF}, '{ST_EMPTY, Q_LOW_LATENCY, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, DSCP_LOW_LATENCY, 1'b0, 16'hFFFF},
            '{ST_DROP_NON_IPV4, Q_LOW_LATENCY, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, DSCP_MACHINE, 1'b0, 16'h0000},
            '{ST_DROP_NON_IPV4, Q_LOW_LATENCY, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, DSCP_LOW_LATENCY, 1'b1, 16'hFFFF},
            '{ST_ENQUEUED, Q_LOW_LATENCY, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, DSCP_BROADBAND, 1'b1, 16'h0000},
            '{ST_ENQUEUED, Q_BROADBAND, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, DSCP_MACHINE, 1'b1, 16'h8001},
            '{ST_ENQUEUED, Q_MACHINE_TYPE, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, 6'd0, 1'b1, 16'h00FF}, '{ST_ENQUEUED, Q_BROADBAND, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, 6'd63, 1'b1, 16'hFF00}, '{ST_ENQUEUED, Q_BROADBAND, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, 6'd47, 1'b1, 16'hA5A5}, '{ST_ENQUEUED, Q_BROADBAND, 16'h0000}},
        '{1'b1, '{KIND_ENQUEUE, 6'd9, 1'b1, 16'h5A5A}, '{ST_ENQUEUED, Q_BROADBAND, 16'h0000}},
        '{1'b0, '{KIND_DEQUEUE, 6'd0, 1'b0, 16'h0000}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, 6'd63, 1'b1, 16'hFFFF}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, 6'd21, 1'b0, 16'h1234}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, 6'd42, 1'b1, 16'hEDCB}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, DSCP_LOW_LATENCY, 1'b1, 16'h0F0F}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, DSCP_MACHINE, 1'b0, 16'hF0F0}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, 6'd1, 1'b1, 16'h0001}, UNTYPED},
        '{1'b0, '{KIND_DEQUEUE, 6'd62, 1'b0, 16'h8000}, UNTYPED}
    };

    logic clk;
    logic rst_n;

    dwrr_req_if #(.HANDLE_BITS(HANDLE_BITS)) req_ch ();
    dwrr_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) rsp_ch ();
    dwrr_cfg_if cfg_ch ();

    dscp_weighted_round_robin_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    logic [HANDLE_BITS-1:0] handle_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0]       rd_ptr     [NUM_QUEUES];
    logic [PTR_W-1:0]       wr_ptr     [NUM_QUEUES];
    logic [OCC_W-1:0]       fill_level [NUM_QUEUES];
    weight_t                credit     [NUM_QUEUES];
    weight_t                weight     [NUM_QUEUES];
    qidx_t                  last_served;

    pkt_rsp_t outcome_q [$];

    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  responses_seen = 0;
    int  dequeued_seen  = 0;
    int  full_seen      = 0;
    int  full_reloads   = 0;
    int  rsp_hold       = 0;
    bit  steady         = 1'b0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic qidx_t class_queue(dscp_t d);
        if (d == DSCP_LOW_LATENCY) return Q_LOW_LATENCY;
        if (d == DSCP_BROADBAND) return Q_BROADBAND;
        if (d == DSCP_MACHINE) return Q_MACHINE_TYPE;
        return Q_BROADBAND;
    endfunction

    function automatic void refill(int q);
        credit[q] = (weight[q] == '0) ? weight_t'(1) : weight[q];
    endfunction

    function automatic int find_served();
        int q;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            q = (int'(last_served) + i) % NUM_QUEUES;
            if (credit[q] != '0 && fill_level[q] != '0) return q;
            if (fill_level[q] == '0) refill(q);
        end
        return NUM_QUEUES;
    endfunction

    function automatic pkt_rsp_t wrr_outcome(pkt_req_t r);
        pkt_rsp_t o;
        int       q;
        o = '{ST_EMPTY, Q_LOW_LATENCY, '0};
        if (r.kind == KIND_ENQUEUE)
        begin
            if (!r.is_ipv4)
            begin
                o.status = ST_DROP_NON_IPV4;
            end
            else
            begin
                q = int'(class_queue(r.dscp));
                o.queue_index = qidx_t'(q);
                if (fill_level[q] >= QUEUE_DEPTH)
                begin
                    o.status = ST_DROP_FULL;
                end
                else
                begin
                    handle_mem[q][wr_ptr[q]] = r.handle;
                    wr_ptr[q] = (wr_ptr[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : wr_ptr[q] + PTR_W'(1);
                    fill_level[q] = fill_level[q] + OCC_W'(1);
                    o.status = ST_ENQUEUED;
                end
            end
        end
        else
        begin
            q = find_served();
            if (q == NUM_QUEUES && (fill_level[0] | fill_level[1] | fill_level[2]) != '0)
            begin
                for (int k = 0; k < NUM_QUEUES; k++)
                    refill(k);
                full_reloads++;
                q = find_served();
            end
            if (q != NUM_QUEUES)
            begin
                o.handle = handle_mem[q][rd_ptr[q]];
                rd_ptr[q] = (rd_ptr[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr[q] + PTR_W'(1);
                fill_level[q] = fill_level[q] - OCC_W'(1);
                credit[q] = credit[q] - weight_t'(1);
                last_served = qidx_t'(q);
                o.queue_index = qidx_t'(q);
                o.status = ST_DEQUEUED;
            end
        end
        return o;
    endfunction

    function automatic pkt_req_t random_request(int deq_pct);
        pkt_req_t r;
        int       pick;
        r.kind = ($urandom_range(0, 99) < deq_pct) ? KIND_DEQUEUE : KIND_ENQUEUE;
        pick = $urandom_range(0, 9);
        if (pick < 3) r.dscp = DSCP_LOW_LATENCY;
        else if (pick < 6) r.dscp = DSCP_BROADBAND;
        else if (pick < 8) r.dscp = DSCP_MACHINE;
        else r.dscp = dscp_t'($urandom);
        r.is_ipv4 = ($urandom_range(0, 9) != 0);
        r.handle = HANDLE_BITS'($urandom);
        return r;
    endfunction

    task automatic send_request(input pkt_req_t r, input logic typed, input pkt_rsp_t e);
        int       gap;
        pkt_rsp_t got;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= r.kind;
        req_ch.dscp          <= r.dscp;
        req_ch.is_ipv4       <= r.is_ipv4;
        req_ch.packet_handle <= r.handle;
        do @(posedge clk); while (!req_ch.ready);
        got = wrr_outcome(r);
        outcome_q.insert(outcome_q.size(), typed ? e : got);
        requests_sent++;
    endtask

    task automatic run_random(input int count, input int deq_pct);
        for (int n = 0; n < count; n++)
            send_request(random_request(deq_pct), 1'b0, UNTYPED);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_weights(input weight_t w0, input weight_t w1, input weight_t w2,
                                input bit poke_unused);
        weight_t w [NUM_QUEUES];
        w[0] = w0;
        w[1] = w1;
        w[2] = w2;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= WEIGHT_REG[k];
            cfg_ch.data  <= w[k];
            do @(posedge clk); while (!cfg_ch.ready);
            weight[k] = w[k];
        end
        if (poke_unused)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_UNUSED;
            cfg_ch.data  <= weight_t'($urandom);
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_ENQUEUE;
        req_ch.dscp          = '0;
        req_ch.is_ipv4       = 1'b0;
        req_ch.packet_handle = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_WEIGHT_LOW_LATENCY;
        cfg_ch.data          = '0;
        weight[0] = WEIGHT_RESET_LOW_LATENCY;
        weight[1] = WEIGHT_RESET_BROADBAND;
        weight[2] = WEIGHT_RESET_MACHINE_TYPE;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            rd_ptr[k]     = '0;
            wr_ptr[k]     = '0;
            fill_level[k] = '0;
            credit[k]     = weight[k];
        end
        last_served = Q_LOW_LATENCY;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_request(DIRECTED[i].r, DIRECTED[i].typed, DIRECTED[i].e);

        settle();
        load_weights(8'd1, 8'd1, 8'd1, 1'b1);
        run_random(40, 45);

        // stall the response side so the request side backs up
        settle();
        load_weights(8'd255, 8'd255, 8'd255, 1'b0);
        rsp_hold = 200;
        run_random(30, 0);
        run_random(25, 40);
        settle();
        run_random(25, 50);

        settle();
        load_weights(8'd0, 8'd0, 8'd0, 1'b1);
        run_random(60, 50);

        // overfill the machine type queue, then run random traffic with 60 percent dequeues
        settle();
        load_weights(8'd128, 8'd1, 8'd3, 1'b0);
        steady = 1'b1;
        for (int n = 0; n < 70; n++)
            send_request('{KIND_ENQUEUE, DSCP_MACHINE, 1'b1, HANDLE_BITS'($urandom)},
                         1'b0, UNTYPED);
        steady = 1'b0;
        run_random(60, 60);

        settle();
        load_weights(weight_t'($urandom), weight_t'($urandom), weight_t'($urandom), 1'b0);
        steady = 1'b1;
        run_random(50, 45);
        steady = 1'b0;
        run_random(50, 45);

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d requests over six weight settings, zero and full-scale included.",
                 requests_sent);
        $display("Checked %0d responses: %0d dequeued, %0d full-queue drops, %0d credit reloads.",
                 responses_seen, dequeued_seen, full_seen, full_reloads);
        if (mismatches == 0)
            $display("dscp_weighted_round_robin_queue_tb passed");
        else
            $display("dscp_weighted_round_robin_queue_tb failed");
        $finish;
    end

    initial
    begin
        pkt_rsp_t want;
        int       gap;
        rsp_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                while (rsp_hold > 0)
                begin
                    @(posedge clk);
                    rsp_hold--;
                end
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            responses_seen++;
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request pending: status %0d queue %0d handle %h",
                             rsp_ch.status, rsp_ch.queue_index, rsp_ch.out_handle);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (want.status == ST_DEQUEUED) dequeued_seen++;
                if (want.status == ST_DROP_FULL) full_seen++;
                if (rsp_ch.status !== want.status || rsp_ch.queue_index !== want.queue_index
                    || rsp_ch.out_handle !== want.handle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on response %0d (status/queue/handle): %s",
                                 responses_seen, "expected vs got");
                    if (mismatches <= 10)
                        $display("  expected %0d/%0d/%h, got %0d/%0d/%h",
                                 want.status, want.queue_index, want.handle,
                                 rsp_ch.status, rsp_ch.queue_index, rsp_ch.out_handle);
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("dscp_weighted_round_robin_queue_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
